/* rtl/att_pkg.sv */
`default_nettype none
package att_pkg;

	// Default number of CORDIC steps and the longest table that is provided
	localparam int CORDIC_ITER_DEF = 16;
	localparam int ATAN_LEN        = 24;

	// Operand width into the CORDIC, vector width inside it, angle width
	localparam int OPD_W = 32;
	localparam int VEC_W = 35;
	localparam int ANG_W = 34;

	// Square root of (y*y + z*z) * 2^30: one result bit per step
	localparam int SQ_STEPS = 31;
	localparam int SUM_W    = 32;
	localparam int REM_W    = 33;

	// Angles in radians scaled by 2^30
	localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd1686629713;

	// round(atan(2^-i) * 2^30)
	localparam logic [29:0] ATAN_TAB [0:ATAN_LEN-1] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128
	};

endpackage
`default_nettype wire

/* rtl/att_cordic.sv */
`default_nettype none
module att_cordic #(
	parameter int ITER = att_pkg::CORDIC_ITER_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic                                  in_vld,
	input  wire logic signed [att_pkg::OPD_W-1:0]      num,
	input  wire logic signed [att_pkg::OPD_W-1:0]      den,
	output logic                                       out_vld,
	output logic signed [att_pkg::ANG_W-1:0]           ang
);
	import att_pkg::*;

	logic                    vld_s  [0:ITER];
	logic signed [VEC_W-1:0] vx_s   [0:ITER];
	logic signed [VEC_W-1:0] vy_s   [0:ITER];
	logic signed [ANG_W-1:0] acc_s  [0:ITER];
	logic signed [ANG_W-1:0] base_s [0:ITER];
	logic                    spc_s  [0:ITER];
	logic signed [ANG_W-1:0] sang_s [0:ITER];

	logic signed [VEC_W-1:0] num_x, den_x;
	logic                    num_zero, den_zero, den_neg;
	logic signed [ANG_W-1:0] spc_ang, base_ang;

	// Classify the operands and turn a left half-plane vector by pi
	always_comb begin
		num_x    = VEC_W'(num);
		den_x    = VEC_W'(den);
		num_zero = (num == '0);
		den_zero = (den == '0);
		den_neg  = den[OPD_W-1];
		if (num_zero) begin
			spc_ang = den_neg ? -ANG_PI : '0;
		end else begin
			spc_ang = num[OPD_W-1] ? -ANG_HALF_PI : ANG_HALF_PI;
		end
		base_ang = '0;
		if (den_neg) begin
			base_ang = num[OPD_W-1] ? -ANG_PI : ANG_PI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spc_s[0]  <= num_zero | den_zero;
			sang_s[0] <= spc_ang;
			base_s[0] <= base_ang;
			vx_s[0]   <= den_neg ? -den_x : den_x;
			vy_s[0]   <= den_neg ? -num_x : num_x;
			acc_s[0]  <= '0;
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < ITER; i++) begin : g_step
		logic signed [VEC_W-1:0] dx, dy;
		logic signed [ANG_W-1:0] step_ang;
		assign dx       = vy_s[i] >>> i;
		assign dy       = vx_s[i] >>> i;
		assign step_ang = ANG_W'({1'b0, ATAN_TAB[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				spc_s[i+1]  <= spc_s[i];
				sang_s[i+1] <= sang_s[i];
				base_s[i+1] <= base_s[i];
				if (!vy_s[i][VEC_W-1]) begin
					vx_s[i+1]  <= vx_s[i] + dx;
					vy_s[i+1]  <= vy_s[i] - dy;
					acc_s[i+1] <= acc_s[i] + step_ang;
				end else begin
					vx_s[i+1]  <= vx_s[i] - dx;
					vy_s[i+1]  <= vy_s[i] + dy;
					acc_s[i+1] <= acc_s[i] - step_ang;
				end
			end
		end
	end

	// Add the base turn, or take the exact angle of an axis vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[ITER];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang <= spc_s[ITER] ? sang_s[ITER] : base_s[ITER] + acc_s[ITER];
		end
	end

endmodule
`default_nettype wire

/* rtl/accel_tilt_to_led_color.sv */
// Tilt to LED colour.
// Input channel: in_valid / in_stall carry one accelerometer word (accel_x,
// accel_y, accel_z). A word is taken at a rising edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall carry pitch_deg,
// roll_deg, red_level and blue_level, one result per input word.
// The two offsets red_base and blue_base sit on the APB port at byte
// addresses 0 and 4; write them only while the block is empty.
// From acceptance to out_valid a word passes registers for the squares and
// their sum, the square root stages (one root bit a stage), the vectoring
// pipelines of pitch and roll running side by side, the stages for scaling
// to degrees and clamping, and the output register. Throughput: one word
// per cycle while in_stall is low; every stage is a register stage.
// Reset empties the pipeline and the output, and sets both offsets to 128.
// When the receiver stalls, the output word is held and one more word is
// parked in a skid register; in_stall then rises and the pipeline freezes
// until the skid register drains. in_stall comes from a register only.
`default_nettype none
module accel_tilt_to_led_color #(
	parameter int CORDIC_ITERATIONS = att_pkg::CORDIC_ITER_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [7:0]       pitch_deg,
	output logic signed [8:0]       roll_deg,
	output logic [7:0]              red_level,
	output logic [7:0]              blue_level,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import att_pkg::*;

	localparam logic REG_RED  = 1'b0;
	localparam logic REG_BLUE = 1'b1;

	logic [7:0] red_base_q, blue_base_q;
	logic       en, skid_vld_q;

	// Configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_base_q  <= 8'd128;
			blue_base_q <= 8'd128;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_RED:  red_base_q  <= pwdata[7:0];
				REG_BLUE: blue_base_q <= pwdata[7:0];
				default:  red_base_q  <= red_base_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RED:  prdata = {24'd0, red_base_q};
			REG_BLUE: prdata = {24'd0, blue_base_q};
			default:  prdata = '0;
		endcase
	end

	// Advance the pipeline whenever the skid register is empty
	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	// Front end: squares, then their sum
	logic                    vld_s1, vld_s2;
	logic [30:0]             sqy_s1, sqz_s1;
	logic [SUM_W-1:0]        sum_s2;
	logic signed [OPD_W-1:0] pnum_s1, rnum_s1, rden_s1;
	logic signed [OPD_W-1:0] pnum_s2, rnum_s2, rden_s2;
	logic [31:0]             sqy_full, sqz_full;

	assign sqy_full = 32'(accel_y * accel_y);
	assign sqz_full = 32'(accel_z * accel_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqy_s1  <= sqy_full[30:0];
			sqz_s1  <= sqz_full[30:0];
			pnum_s1 <= -{{1{accel_x[15]}}, accel_x, 15'd0};
			rnum_s1 <= -{{1{accel_y[15]}}, accel_y, 15'd0};
			rden_s1 <= {{1{accel_z[15]}}, accel_z, 15'd0};
			sum_s2  <= SUM_W'(sqy_s1) + SUM_W'(sqz_s1);
			pnum_s2 <= pnum_s1;
			rnum_s2 <= rnum_s1;
			rden_s2 <= rden_s1;
		end
	end

	// Square root of sum * 2^30, one root bit per stage
	logic                    sq_vld_s  [0:SQ_STEPS-1];
	logic [REM_W-1:0]        sq_rem_s  [0:SQ_STEPS-1];
	logic [SQ_STEPS-1:0]     sq_root_s [0:SQ_STEPS-1];
	logic [SUM_W-1:0]        sq_sum_s  [0:SQ_STEPS-1];
	logic signed [OPD_W-1:0] sq_pnum_s [0:SQ_STEPS-1];
	logic signed [OPD_W-1:0] sq_rnum_s [0:SQ_STEPS-1];
	logic signed [OPD_W-1:0] sq_rden_s [0:SQ_STEPS-1];

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		logic                    p_vld;
		logic [REM_W-1:0]        p_rem;
		logic [SQ_STEPS-1:0]     p_root;
		logic [SUM_W-1:0]        p_sum;
		logic signed [OPD_W-1:0] p_pnum, p_rnum, p_rden;
		logic [2*SQ_STEPS-1:0]   rad;
		logic [REM_W+1:0]        trial_rem, trial_sub;
		logic                    fits;

		if (j == 0) begin : g_first
			assign p_vld  = vld_s2;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_sum  = sum_s2;
			assign p_pnum = pnum_s2;
			assign p_rnum = rnum_s2;
			assign p_rden = rden_s2;
		end else begin : g_next
			assign p_vld  = sq_vld_s[j-1];
			assign p_rem  = sq_rem_s[j-1];
			assign p_root = sq_root_s[j-1];
			assign p_sum  = sq_sum_s[j-1];
			assign p_pnum = sq_pnum_s[j-1];
			assign p_rnum = sq_rnum_s[j-1];
			assign p_rden = sq_rden_s[j-1];
		end

		assign rad       = {p_sum, 30'd0};
		assign trial_rem = {p_rem, rad[2*SQ_STEPS-1-2*j -: 2]};
		assign trial_sub = {1'b0, p_root, 2'b01};
		assign fits      = (trial_rem >= trial_sub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j] <= 1'b0;
			end else if (en) begin
				sq_vld_s[j] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[j]  <= fits ? REM_W'(trial_rem - trial_sub) : REM_W'(trial_rem);
				sq_root_s[j] <= {p_root[SQ_STEPS-2:0], fits};
				sq_sum_s[j]  <= p_sum;
				sq_pnum_s[j] <= p_pnum;
				sq_rnum_s[j] <= p_rnum;
				sq_rden_s[j] <= p_rden;
			end
		end
	end

	// Pitch and roll vectoring in lockstep
	logic                    cv_p, cv_r;
	logic signed [ANG_W-1:0] ang_p, ang_r;

	att_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld_s[SQ_STEPS-1]),
		.num     (sq_pnum_s[SQ_STEPS-1]),
		.den     (OPD_W'(sq_root_s[SQ_STEPS-1])),
		.out_vld (cv_p),
		.ang     (ang_p)
	);

	att_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld_s[SQ_STEPS-1]),
		.num     (sq_rnum_s[SQ_STEPS-1]),
		.den     (sq_rden_s[SQ_STEPS-1]),
		.out_vld (cv_r),
		.ang     (ang_r)
	);

	// Degrees: trunc(|ang| * 287 / 2^30 / 5), sign put back
	logic [ANG_W-1:0]        mag_p_full, mag_r_full;
	logic [41:0]             prod_p, prod_r;
	logic                    dg_vld_s1, dg_vld_s2, dg_vld_s3;
	logic [41:0]             dg_prod_p_s1, dg_prod_r_s1;
	logic                    dg_neg_p_s1, dg_neg_r_s1;
	logic [25:0]             quo_p, quo_r;
	logic signed [10:0]      dg_pitch_s2, dg_roll_s2;
	logic signed [10:0]      red_sum, blue_sum;
	logic [7:0]              red_clip, blue_clip;
	logic signed [7:0]       dg_pitch_s3;
	logic signed [8:0]       dg_roll_s3;
	logic [7:0]              dg_red_s3, dg_blue_s3;

	assign mag_p_full = ang_p[ANG_W-1] ? ANG_W'(-ang_p) : ANG_W'(ang_p);
	assign mag_r_full = ang_r[ANG_W-1] ? ANG_W'(-ang_r) : ANG_W'(ang_r);
	assign prod_p     = 42'(mag_p_full[32:0]) * 42'd287;
	assign prod_r     = 42'(mag_r_full[32:0]) * 42'd287;

	// Divide by five through a reciprocal, exact below 4096
	assign quo_p = 26'(dg_prod_p_s1[41:30]) * 26'd13108;
	assign quo_r = 26'(dg_prod_r_s1[41:30]) * 26'd13108;

	assign red_sum  = 11'($signed({3'd0, red_base_q})) + dg_pitch_s2 + dg_roll_s2;
	assign blue_sum = 11'($signed({3'd0, blue_base_q})) + dg_pitch_s2 - dg_roll_s2;

	// Clamp to 0..255
	always_comb begin
		priority if (red_sum < 0) begin
			red_clip = 8'd0;
		end else if (red_sum > 11'sd255) begin
			red_clip = 8'hff;
		end else begin
			red_clip = red_sum[7:0];
		end
		priority if (blue_sum < 0) begin
			blue_clip = 8'd0;
		end else if (blue_sum > 11'sd255) begin
			blue_clip = 8'hff;
		end else begin
			blue_clip = blue_sum[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dg_vld_s1 <= 1'b0;
			dg_vld_s2 <= 1'b0;
			dg_vld_s3 <= 1'b0;
		end else if (en) begin
			dg_vld_s1 <= cv_p;
			dg_vld_s2 <= dg_vld_s1;
			dg_vld_s3 <= dg_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dg_prod_p_s1 <= prod_p;
			dg_prod_r_s1 <= prod_r;
			dg_neg_p_s1  <= ang_p[ANG_W-1];
			dg_neg_r_s1  <= ang_r[ANG_W-1];
			dg_pitch_s2  <= dg_neg_p_s1 ? -$signed({1'b0, quo_p[25:16]})
			                            : $signed({1'b0, quo_p[25:16]});
			dg_roll_s2   <= dg_neg_r_s1 ? -$signed({1'b0, quo_r[25:16]})
			                            : $signed({1'b0, quo_r[25:16]});
			dg_pitch_s3  <= dg_pitch_s2[7:0];
			dg_roll_s3   <= dg_roll_s2[8:0];
			dg_red_s3    <= red_clip;
			dg_blue_s3   <= blue_clip;
		end
	end

	// Output register with one skid word behind it
	logic               take;
	logic signed [7:0]  skid_pitch_q;
	logic signed [8:0]  skid_roll_q;
	logic [7:0]         skid_red_q, skid_blue_q;

	assign take = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take) begin
			if (skid_vld_q) begin
				out_valid  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_valid <= dg_vld_s3;
			end
		end else if (dg_vld_s3 && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_vld_q) begin
				pitch_deg  <= skid_pitch_q;
				roll_deg   <= skid_roll_q;
				red_level  <= skid_red_q;
				blue_level <= skid_blue_q;
			end else begin
				pitch_deg  <= dg_pitch_s3;
				roll_deg   <= dg_roll_s3;
				red_level  <= dg_red_s3;
				blue_level <= dg_blue_s3;
			end
		end else if (en) begin
			skid_pitch_q <= dg_pitch_s3;
			skid_roll_q  <= dg_roll_s3;
			skid_red_q   <= dg_red_s3;
			skid_blue_q  <= dg_blue_s3;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_valid)
		else $error("skid word held with empty output register");

	a_cordic_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		cv_p == cv_r)
		else $error("pitch and roll pipelines out of step");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_deg >= -8'sd90 && pitch_deg <= 8'sd90))
		else $error("pitch out of range");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_deg >= -9'sd180 && roll_deg <= 9'sd180))
		else $error("roll out of range");
`endif

endmodule
`default_nettype wire
